[rtl/core/battery_voltage_averager_top_assert.svh]
// Assertion macros shared by the battery voltage averager RTL.
`ifndef BATTERY_VOLTAGE_AVERAGER_TOP_ASSERT_SVH
`define BATTERY_VOLTAGE_AVERAGER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BVA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define BVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/bva_pkg.sv]
// Types and constants of the battery voltage averager.
`timescale 1ns / 1ps

package bva_pkg;

	localparam int ADC_BITS = 12;
	localparam int GAIN_W   = 24;
	localparam int MV_W     = 16;
	localparam int PCT_W    = 7;
	// (v - empty) * 100 fits in 23 bits
	localparam int PCT_NUM_W = MV_W + PCT_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(158434);
	localparam logic [MV_W-1:0]   FULL_RESET  = MV_W'(7400);
	localparam logic [MV_W-1:0]   EMPTY_RESET = MV_W'(6000);
	localparam logic [MV_W-1:0]   HELD_RESET  = MV_W'(7400);
	localparam logic [PCT_W-1:0]  PCT_FULL    = PCT_W'(100);
	localparam logic [PCT_W-1:0]  PCT_EMPTY   = PCT_W'(0);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN  = 2'd0,
		REG_FULL  = 2'd1,
		REG_EMPTY = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [ADC_BITS-1:0] sample;
		logic                sample_ok;
	} bva_in_t;

	typedef struct packed {
		logic [MV_W-1:0]  voltage_mv;
		logic [PCT_W-1:0] percent;
		logic             low_battery;
	} bva_out_t;

	// handshake between the sequencer and a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MUL_WAIT,
		ST_PCT_GO,
		ST_PCT_WAIT,
		ST_EMIT
	} st_t;

endpackage

[rtl/core/battery_voltage_averager_top.sv]
// Top level of the battery voltage averager: accumulation, sequencer, result register.
//
// Channel   Signals                              Direction  Moves
// smp       smp_valid, smp_stall, smp            in         one ADC attempt
// res       res_valid, res_stall, res            out        voltage, percent, low flag
// cfg       cfg_valid, cfg_ready, cfg_index/data in         one register write
//
// The attempt that closes a batch starts the bit-serial divider (DIV_N is 23 at default
// size) for the mean if the batch has good samples, the serial multiplier for the gain,
// and the divider again for the percent unless the voltage is at or past the full or
// empty level; smp_stall is high from the batch end until the result is emitted.
// Reset is asynchronous, active low; it loads the register defaults and a 7400 mV voltage.
// A result waiting on res_stall does not block accumulation; only the next batch end waits.
`timescale 1ns / 1ps

`include "battery_voltage_averager_top_assert.svh"

module battery_voltage_averager_top #(
	parameter int BATCH_SIZE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              smp_valid,
	output logic                              smp_stall,
	input  bva_pkg::bva_in_t                  smp,
	output logic                              res_valid,
	input  logic                              res_stall,
	output bva_pkg::bva_out_t                 res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bva_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bva_pkg::GAIN_W-1:0]        cfg_data
);
	import bva_pkg::*;

	localparam int CNT_W = $clog2(BATCH_SIZE + 1);
	localparam int SUM_W = ADC_BITS + CNT_W;
	localparam int DIV_N = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
	localparam int DIV_D = MV_W;
	localparam int PRD_W = ADC_BITS + GAIN_W;

	st_t               state_q, state_d;
	logic [GAIN_W-1:0] gain_q;
	logic [MV_W-1:0]   full_q;
	logic [MV_W-1:0]   empty_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  good_q;
	logic [CNT_W-1:0]  attempt_q;
	logic [MV_W-1:0]   held_q;
	logic [PCT_W-1:0]  pct_q;
	logic              res_valid_q;
	bva_out_t          res_q;

	logic              smp_acc;
	logic              res_free;
	logic              div_start;
	logic [DIV_N-1:0]  div_num;
	logic [DIV_D-1:0]  div_den;
	logic [DIV_N-1:0]  div_quo;
	unit_stat_t        div_stat;
	logic              mul_start;
	logic [PRD_W-1:0]  mul_prod;
	unit_stat_t        mul_stat;
	logic [MV_W-1:0]   scaled_mv;
	logic [MV_W-1:0]   span_low;
	logic [PCT_NUM_W-1:0] pct_num;

	assign cfg_ready = 1'b1;
	assign smp_acc   = smp_valid && !smp_stall;
	assign res_free  = !res_valid_q || !res_stall;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			full_q  <= FULL_RESET;
			empty_q <= EMPTY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN:  gain_q  <= cfg_data;
				REG_FULL:  full_q  <= cfg_data[MV_W-1:0];
				REG_EMPTY: empty_q <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// mean times gain, Q16, saturated to 16 bits
	assign scaled_mv = (|mul_prod[PRD_W-1:2*MV_W]) ? '1 : mul_prod[2*MV_W-1:MV_W];

	// (v - empty) * 100 as shifts and adds
	assign span_low = held_q - empty_q;
	assign pct_num  = (PCT_NUM_W'(span_low) << 6) + (PCT_NUM_W'(span_low) << 5)
		+ (PCT_NUM_W'(span_low) << 2);

	// divider operands: mean in the first pass, percent in the second
	always_comb begin
		if (state_q == ST_MEAN_GO) begin
			div_num = DIV_N'(sum_q);
			div_den = DIV_D'(good_q);
		end else begin
			div_num = DIV_N'(pct_num);
			div_den = full_q - empty_q;
		end
	end

	bva_div #(
		.N(DIV_N),
		.D(DIV_D)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	bva_mul #(
		.A_W(ADC_BITS),
		.B_W(GAIN_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (div_quo[ADC_BITS-1:0]),
		.b       (gain_q),
		.product (mul_prod),
		.stat    (mul_stat)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit strobes
	always_comb begin
		state_d   = state_q;
		smp_stall = 1'b1;
		div_start = 1'b0;
		mul_start = 1'b0;
		case (state_q)
			ST_ACC: begin
				smp_stall = 1'b0;
				if (smp_acc && attempt_q == CNT_W'(BATCH_SIZE - 1)) begin
					state_d = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO: begin
				if (good_q == '0) begin
					state_d = ST_PCT_GO;
				end else begin
					div_start = 1'b1;
					state_d   = ST_MEAN_WAIT;
				end
			end
			ST_MEAN_WAIT: begin
				if (div_stat.done) begin
					mul_start = 1'b1;
					state_d   = ST_MUL_WAIT;
				end
			end
			ST_MUL_WAIT: begin
				if (mul_stat.done) begin
					state_d = ST_PCT_GO;
				end
			end
			ST_PCT_GO: begin
				if (held_q >= full_q || held_q <= empty_q) begin
					state_d = ST_EMIT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_PCT_WAIT;
				end
			end
			ST_PCT_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (res_free) begin
					state_d = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	// batch accumulation and held voltage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			good_q    <= '0;
			attempt_q <= '0;
			held_q    <= HELD_RESET;
		end else begin
			if (smp_acc) begin
				if (smp.sample_ok) begin
					sum_q  <= sum_q + SUM_W'(smp.sample);
					good_q <= good_q + CNT_W'(1);
				end
				if (attempt_q == CNT_W'(BATCH_SIZE - 1)) begin
					attempt_q <= '0;
				end else begin
					attempt_q <= attempt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_MEAN_GO) begin
				sum_q  <= '0;
				good_q <= '0;
			end
			if (state_q == ST_MUL_WAIT && mul_stat.done) begin
				held_q <= scaled_mv;
			end
		end
	end

	// percent: clamped ends or the divider quotient
	always_ff @(posedge clk) begin
		if (state_q == ST_PCT_GO) begin
			pct_q <= (held_q >= full_q) ? PCT_FULL : PCT_EMPTY;
		end else if (state_q == ST_PCT_WAIT && div_stat.done) begin
			pct_q <= div_quo[PCT_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && res_free) begin
			res_q.voltage_mv  <= held_q;
			res_q.percent     <= pct_q;
			res_q.low_battery <= held_q < empty_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`BVA_ASSERT_IMPL(a_pct_range, clk, arst_n, res_valid, res.percent <= PCT_FULL)
	`BVA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(res))
	`BVA_ASSERT_IMPL(a_div_done_wait, clk, arst_n, div_stat.done,
		state_q == ST_MEAN_WAIT || state_q == ST_PCT_WAIT)
	`BVA_ASSERT_NEXT(a_batch_wrap, clk, arst_n,
		smp_acc && attempt_q == CNT_W'(BATCH_SIZE - 1), state_q == ST_MEAN_GO)

endmodule

[rtl/core/bva_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bva_div #(
	parameter int N = 24,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [N-1:0]         dividend,
	input  logic [D-1:0]         divisor,
	output logic [N-1:0]         quotient,
	output bva_pkg::unit_stat_t  stat
);
	import bva_pkg::*;

	localparam int CNT_W = $clog2(N + 1);

	logic [N-1:0]     q_q;
	logic [D-1:0]     r_q;
	logic [D-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D+1:0]     diff;
	logic [D:0]       shifted;
	logic             neg;

	// trial subtract of the divisor from the shifted partial remainder
	assign shifted = {r_q, q_q[N-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign neg     = diff[D+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			r_q   <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			r_q <= neg ? shifted[D-1:0] : diff[D-1:0];
			q_q <= {q_q[N-2:0], ~neg};
		end
	end

	assign quotient  = q_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/core/bva_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module bva_mul #(
	parameter int A_W = 12,
	parameter int B_W = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic [A_W+B_W-1:0]   product,
	output bva_pkg::unit_stat_t  stat
);
	import bva_pkg::*;

	localparam int CNT_W = $clog2(A_W + 1);

	logic [B_W-1:0]   hi_q;
	logic [A_W-1:0]   lo_q;
	logic [B_W-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [B_W:0]     psum;

	// add the multiplicand when the current low bit is set
	assign psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(A_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// product shifts right one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= a;
			b_q  <= b;
		end else if (busy_q) begin
			hi_q <= psum[B_W:1];
			lo_q <= {psum[0], lo_q[A_W-1:1]};
		end
	end

	assign product   = {hi_q, lo_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
